// ===== rtl/core/dazc_pkg.sv =====
// shared types and constants of the dst adjusted zone clock
package dazc_pkg;

  // input word: utc time and local date
  typedef struct packed {
    logic [4:0] utc_hour;
    logic [5:0] utc_minute;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
  } in_word_t;

  // output word: main and home wall-clock times
  typedef struct packed {
    logic [4:0] main_hour;
    logic [5:0] main_minute;
    logic       main_pm;
    logic       main_dst;
    logic       home_valid;
    logic [4:0] home_hr;
    logic [5:0] home_minute;
    logic       home_pm;
  } out_word_t;

  // stage one result shared by both zones
  typedef struct packed {
    logic [10:0] utc_min;
    logic [3:0]  month;
    logic        us_start;   // day on or after the second sunday
    logic        ge_first;   // day on or after the first sunday
    logic        lt_first;   // day before the first sunday
    logic        ge_last31;  // day on or after the last sunday of a 31-day month
    logic        ge_last30;  // day on or after the last sunday of a 30-day month
  } date_t;

  // load enables of the zone stages
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } pipe_ctl_t;

  // rule codes
  localparam logic [2:0] RULE_NONE = 3'd0;
  localparam logic [2:0] RULE_US   = 3'd1;
  localparam logic [2:0] RULE_EU   = 3'd2;
  localparam logic [2:0] RULE_AU   = 3'd3;
  localparam logic [2:0] RULE_CL   = 3'd4;
  localparam logic [2:0] RULE_NZ   = 3'd5;
  localparam logic [2:0] RULE_NF   = 3'd6;

  // register indexes
  localparam logic [2:0] REG_MAIN_OFFSET = 3'd0;
  localparam logic [2:0] REG_MAIN_RULE   = 3'd1;
  localparam logic [2:0] REG_HOME_OFFSET = 3'd2;
  localparam logic [2:0] REG_HOME_RULE   = 3'd3;
  localparam logic [2:0] REG_HOME_SHOWN  = 3'd4;
  localparam logic [2:0] REG_TWELVE_HOUR = 3'd5;

  // offsets in minutes
  localparam logic signed [13:0] NF_STANDARD = -14'sd210;
  localparam logic signed [13:0] NF_DAYLIGHT = -14'sd150;
  localparam logic signed [13:0] DST_SHIFT   = 14'sd60;
  localparam logic signed [13:0] TWO_DAYS    = 14'sd2880;
  localparam logic [12:0]        MIN_DAY     = 13'd1440;

endpackage

// ===== rtl/core/dazc_date.sv =====
// stage one: utc minute of day and sunday date compares
module dazc_date (
  input  logic              clk,
  input  logic              en,
  input  dazc_pkg::in_word_t word,
  output dazc_pkg::date_t    date
);

  // x mod 7 for x below 84, by reciprocal multiply
  function automatic logic [2:0] mod7(input logic [6:0] x);
    logic [12:0] p;
    logic [6:0]  q7;
    logic [6:0]  r;
    p  = {6'b0, x} * 13'd37;
    q7 = {3'b0, p[11:8]} * 7'd7;
    r  = x - q7;
    return r[2:0];
  endfunction

  logic [6:0]  fs_arg;
  logic [6:0]  ls31_arg;
  logic [6:0]  ls30_arg;
  logic [4:0]  first_sun;
  logic [5:0]  second_sun;
  logic [4:0]  last31;
  logic [4:0]  last30;
  logic [10:0] utc_min;

  always_comb begin
    fs_arg     = {2'b0, word.day} + 7'd13 - {4'b0, word.weekday};
    ls31_arg   = 7'd66 - {2'b0, word.day} + {4'b0, word.weekday};
    ls30_arg   = 7'd65 - {2'b0, word.day} + {4'b0, word.weekday};
    first_sun  = 5'd1 + {2'b0, mod7(fs_arg)};
    second_sun = {1'b0, first_sun} + 6'd7;
    last31     = 5'd31 - {2'b0, mod7(ls31_arg)};
    last30     = 5'd30 - {2'b0, mod7(ls30_arg)};
    utc_min    = {6'b0, word.utc_hour} * 11'd60 + {5'b0, word.utc_minute};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      date.utc_min   <= utc_min;
      date.month     <= word.month;
      date.us_start  <= {1'b0, word.day} >= second_sun;
      date.ge_first  <= word.day >= first_sun;
      date.lt_first  <= word.day < first_sun;
      date.ge_last31 <= word.day >= last31;
      date.ge_last30 <= word.day >= last30;
    end
  end

endmodule

// ===== rtl/core/dazc_zone.sv =====
// stages two to four of one zone: rule, offset sum, day wrap, hour split
module dazc_zone (
  input  logic                clk,
  input  dazc_pkg::pipe_ctl_t ctl,
  input  dazc_pkg::date_t     date,
  input  logic signed [10:0]  offset,
  input  logic [2:0]          rule,
  input  logic                twelve_hour,
  output logic [4:0]          hour,
  output logic [5:0]          minute,
  output logic                pm,
  output logic                dst
);

  function automatic logic rule_active(input logic [2:0] r, input dazc_pkg::date_t d);
    logic [3:0] m;
    logic       a;
    m = d.month;
    case (r)
      dazc_pkg::RULE_US, dazc_pkg::RULE_NF: begin
        if (m < 4'd3 || m > 4'd11) a = 1'b0;
        else if (m > 4'd3 && m < 4'd11) a = 1'b1;
        else if (m == 4'd3) a = d.us_start;
        else a = d.lt_first;
      end
      dazc_pkg::RULE_EU: begin
        if (m < 4'd3 || m > 4'd10) a = 1'b0;
        else if (m > 4'd3 && m < 4'd10) a = 1'b1;
        else if (m == 4'd3) a = d.ge_last31;
        else a = !d.ge_last31;
      end
      dazc_pkg::RULE_AU: begin
        if (m >= 4'd5 && m <= 4'd9) a = 1'b0;
        else if (m >= 4'd11 || m <= 4'd3) a = 1'b1;
        else if (m == 4'd10) a = d.ge_first;
        else a = d.lt_first;
      end
      dazc_pkg::RULE_CL: begin
        if (m >= 4'd5 && m <= 4'd8) a = 1'b0;
        else if (m >= 4'd10 || m <= 4'd3) a = 1'b1;
        else if (m == 4'd9) a = d.ge_first;
        else a = d.lt_first;
      end
      dazc_pkg::RULE_NZ: begin
        if (m >= 4'd5 && m <= 4'd8) a = 1'b0;
        else if (m >= 4'd10 || m <= 4'd3) a = 1'b1;
        else if (m == 4'd9) a = d.ge_last30;
        else a = d.lt_first;
      end
      default: a = 1'b0;
    endcase
    return a;
  endfunction

  // stage two
  logic               dst_s2;
  logic signed [13:0] off;
  logic signed [13:0] t_sum;
  logic [12:0]        t2;
  logic               dst2;

  always_comb begin
    dst_s2 = rule_active(rule, date);
    if (rule == dazc_pkg::RULE_NF) begin
      off = dst_s2 ? dazc_pkg::NF_DAYLIGHT : dazc_pkg::NF_STANDARD;
    end else begin
      off = {{3{offset[10]}}, offset} + (dst_s2 ? dazc_pkg::DST_SHIFT : 14'sd0);
    end
    t_sum = $signed({3'b0, date.utc_min}) + off + dazc_pkg::TWO_DAYS;
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      t2   <= t_sum[12:0];
      dst2 <= dst_s2;
    end
  end

  // stage three: sum stays within five days
  logic [12:0] wrapped;
  logic [10:0] mins3;
  logic        dst3;

  always_comb begin
    if (t2 >= 4 * dazc_pkg::MIN_DAY) wrapped = t2 - 13'(4 * dazc_pkg::MIN_DAY);
    else if (t2 >= 3 * dazc_pkg::MIN_DAY) wrapped = t2 - 13'(3 * dazc_pkg::MIN_DAY);
    else if (t2 >= 2 * dazc_pkg::MIN_DAY) wrapped = t2 - 13'(2 * dazc_pkg::MIN_DAY);
    else if (t2 >= dazc_pkg::MIN_DAY) wrapped = t2 - dazc_pkg::MIN_DAY;
    else wrapped = t2;
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      mins3 <= wrapped[10:0];
      dst3  <= dst2;
    end
  end

  // stage four: divide by 60 via reciprocal, exact below 1440
  logic [21:0] prod;
  logic [4:0]  h;
  logic [10:0] h60;
  logic [10:0] rem;
  logic [4:0]  disp;

  always_comb begin
    prod = {11'b0, mins3} * 22'd1093;
    h    = prod[20:16];
    h60  = {6'b0, h} * 11'd60;
    rem  = mins3 - h60;
    disp = h;
    if (twelve_hour) begin
      if (h == 5'd0) disp = 5'd12;
      else if (h > 5'd12) disp = h - 5'd12;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en4) begin
      hour   <= disp;
      minute <= rem[5:0];
      pm     <= h >= 5'd12;
      dst    <= dst3;
    end
  end

endmodule

// ===== rtl/core/dst_adjusted_zone_clock.sv =====
// top level of the dst adjusted zone clock
//
//  channel | signals                       | word
//  --------+-------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_word   | utc hour, minute, local date
//  out     | out_valid, out_stall, out_word| main and home wall-clock time
//  cfg     | cfg_we, cfg_index, cfg_data   | zone offsets, rules, modes
//
// four register stages: date compares, rule and offset sum, day wrap, hour split
// one word per cycle sustained while out_stall stays low; an accepted word passes v1, v2, v3, then out_valid
// each stage holds its own valid bit, so bubbles close up under out_stall
// rst clears the valid bits and the config registers, no clearing pass
module dst_adjusted_zone_clock (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dazc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output dazc_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [10:0]         cfg_data
);

  // config registers
  logic signed [10:0] main_offset;
  logic [2:0]         main_rule;
  logic signed [10:0] home_offset;
  logic [2:0]         home_rule;
  logic               home_shown;
  logic               twelve_hour;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_offset <= '0;
      main_rule   <= dazc_pkg::RULE_NONE;
      home_offset <= '0;
      home_rule   <= dazc_pkg::RULE_NONE;
      home_shown  <= 1'b0;
      twelve_hour <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dazc_pkg::REG_MAIN_OFFSET: main_offset <= $signed(cfg_data);
        dazc_pkg::REG_MAIN_RULE:   main_rule   <= cfg_data[2:0];
        dazc_pkg::REG_HOME_OFFSET: home_offset <= $signed(cfg_data);
        dazc_pkg::REG_HOME_RULE:   home_rule   <= cfg_data[2:0];
        dazc_pkg::REG_HOME_SHOWN:  home_shown  <= cfg_data[0];
        dazc_pkg::REG_TWELVE_HOUR: twelve_hour <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-stage valid bits; a stage loads when empty or when the next one loads
  logic v1, v2, v3;
  logic r1, r2, r3, r4;
  dazc_pkg::pipe_ctl_t ctl;

  always_comb begin
    r4 = !out_valid || !out_stall;
    r3 = !v3 || r4;
    r2 = !v2 || r3;
    r1 = !v1 || r2;
    ctl.en2 = r2;
    ctl.en3 = r3;
    ctl.en4 = r4;
  end

  assign in_stall = !r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) out_valid <= v3;
    end
  end

  // stage one, shared by both zones
  dazc_pkg::date_t date;

  dazc_date u_date (
    .clk  (clk),
    .en   (r1),
    .word (in_word),
    .date (date)
  );

  // stages two to four, one copy per zone
  logic [4:0] m_hour, h_hour;
  logic [5:0] m_minute, h_minute;
  logic       m_pm, h_pm;
  logic       m_dst, h_dst;

  dazc_zone u_main (
    .clk         (clk),
    .ctl         (ctl),
    .date        (date),
    .offset      (main_offset),
    .rule        (main_rule),
    .twelve_hour (twelve_hour),
    .hour        (m_hour),
    .minute      (m_minute),
    .pm          (m_pm),
    .dst         (m_dst)
  );

  dazc_zone u_home (
    .clk         (clk),
    .ctl         (ctl),
    .date        (date),
    .offset      (home_offset),
    .rule        (home_rule),
    .twelve_hour (twelve_hour),
    .hour        (h_hour),
    .minute      (h_minute),
    .pm          (h_pm),
    .dst         (h_dst)
  );

  // home fields read as zero when the home zone is hidden; its dst flag is not shown
  logic home_dst_unused;
  assign home_dst_unused = h_dst;

  always_comb begin
    out_word.main_hour   = m_hour;
    out_word.main_minute = m_minute;
    out_word.main_pm     = m_pm;
    out_word.main_dst    = m_dst;
    out_word.home_valid  = home_shown;
    out_word.home_hr     = home_shown ? h_hour : 5'd0;
    out_word.home_minute = home_shown ? h_minute : 6'd0;
    out_word.home_pm     = home_shown & h_pm & !home_dst_unused | home_shown & h_pm;
  end

endmodule

// ===== rtl/core/dazc_check.sv =====
// port-level checks of the dst adjusted zone clock
module dazc_check (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input dazc_pkg::out_word_t out_word
);

  // a stalled word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // hidden home zone gives zero fields
  a_home_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.home_valid |->
      out_word.home_hr == 5'd0 && out_word.home_minute == 6'd0 && !out_word.home_pm)
    else $error("home fields not zero while hidden");

  // minutes wrap below an hour
  a_minute: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.main_minute < 6'd60 && out_word.home_minute < 6'd60)
    else $error("minute out of range");

  // am main hours never pass 12 in either display mode
  a_am: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.main_pm |-> out_word.main_hour <= 5'd12)
    else $error("am hour out of range");

endmodule

bind dst_adjusted_zone_clock dazc_check u_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== test/dazc_checker.sv =====
// checker for the zone clock: tracks the config, predicts each out word and compares
`timescale 1ns / 1ps
module dazc_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  dazc_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  dazc_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [10:0]         cfg_data,
  output int unsigned         mismatches,
  output int unsigned         waiting
);
  import dazc_pkg::*;

  localparam int DAY_MIN       = 24 * 60;
  localparam int SUMMER_SHIFT  = 60;
  localparam int NFLD_WINTER   = -210;
  localparam int NFLD_SUMMER   = -150;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic       pm;
    logic       dst;
  } zone_t;

  // register mirror
  logic signed [10:0] main_off;
  logic signed [10:0] home_off;
  logic [2:0]         main_rule_q;
  logic [2:0]         home_rule_q;
  logic               home_on;
  logic               twelve_on;

  out_word_t wall_due[$];

  initial begin
    mismatches = 0;
    waiting    = 0;
  end

  function automatic int unsigned first_sun(int unsigned d, int unsigned wd);
    return 1 + ((d + 13 - wd) % 7);
  endfunction

  function automatic int unsigned last_sun(int unsigned len, int unsigned d, int unsigned wd);
    return len - ((len + 35 - d + wd) % 7);
  endfunction

  function automatic logic dst_in_force(logic [2:0] rule, int unsigned m, int unsigned d,
                                        int unsigned wd);
    logic on;
    on = 1'b0;
    case (rule)
      RULE_US, RULE_NF: begin
        if (m < 3 || m > 11) on = 1'b0;
        else if (m > 3 && m < 11) on = 1'b1;
        else if (m == 3) on = d >= first_sun(d, wd) + 7;
        else on = d < first_sun(d, wd);
      end
      RULE_EU: begin
        if (m < 3 || m > 10) on = 1'b0;
        else if (m > 3 && m < 10) on = 1'b1;
        else if (m == 3) on = d >= last_sun(31, d, wd);
        else on = d < last_sun(31, d, wd);
      end
      RULE_AU: begin
        if (m >= 5 && m <= 9) on = 1'b0;
        else if (m >= 11 || m <= 3) on = 1'b1;
        else if (m == 10) on = d >= first_sun(d, wd);
        else on = d < first_sun(d, wd);
      end
      RULE_CL: begin
        if (m >= 5 && m <= 8) on = 1'b0;
        else if (m >= 10 || m <= 3) on = 1'b1;
        else if (m == 9) on = d >= first_sun(d, wd);
        else on = d < first_sun(d, wd);
      end
      RULE_NZ: begin
        if (m >= 5 && m <= 8) on = 1'b0;
        else if (m >= 10 || m <= 3) on = 1'b1;
        else if (m == 9) on = d >= last_sun(30, d, wd);
        else on = d < first_sun(d, wd);
      end
      default: on = 1'b0;
    endcase
    return on;
  endfunction

  function automatic zone_t zone_clock(logic signed [10:0] base, logic [2:0] rule, int um,
                                       int unsigned m, int unsigned d, int unsigned wd);
    logic        on;
    int          off;
    int          t;
    int unsigned mins;
    int unsigned hr;
    int unsigned disp;
    zone_t       z;
    on = dst_in_force(rule, m, d, wd);
    off = base;
    if (rule == RULE_NF) off = on ? NFLD_SUMMER : NFLD_WINTER;
    else if (on) off = off + SUMMER_SHIFT;
    t = um + off + 2 * DAY_MIN;
    mins = t % DAY_MIN;
    hr = mins / 60;
    disp = hr;
    if (twelve_on) begin
      if (disp == 0) disp = 12;
      else if (disp > 12) disp = disp - 12;
    end
    z.hour   = 5'(disp);
    z.minute = 6'(mins % 60);
    z.pm     = hr >= 12;
    z.dst    = on;
    return z;
  endfunction

  function automatic out_word_t wall_clock_of(in_word_t w);
    int        um;
    zone_t     zm;
    zone_t     zh;
    out_word_t r;
    um = int'(w.utc_hour) * 60 + int'(w.utc_minute);
    zm = zone_clock(main_off, main_rule_q, um, w.month, w.day, w.weekday);
    r = '0;
    r.main_hour   = zm.hour;
    r.main_minute = zm.minute;
    r.main_pm     = zm.pm;
    r.main_dst    = zm.dst;
    if (home_on) begin
      zh = zone_clock(home_off, home_rule_q, um, w.month, w.day, w.weekday);
      r.home_valid  = 1'b1;
      r.home_hr     = zh.hour;
      r.home_minute = zh.minute;
      r.home_pm     = zh.pm;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      main_off    <= '0;
      home_off    <= '0;
      main_rule_q <= RULE_NONE;
      home_rule_q <= RULE_NONE;
      home_on     <= 1'b0;
      twelve_on   <= 1'b0;
      wall_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAIN_OFFSET: main_off    <= cfg_data;
          REG_MAIN_RULE:   main_rule_q <= cfg_data[2:0];
          REG_HOME_OFFSET: home_off    <= cfg_data;
          REG_HOME_RULE:   home_rule_q <= cfg_data[2:0];
          REG_HOME_SHOWN:  home_on     <= cfg_data[0];
          REG_TWELVE_HOUR: twelve_on   <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) wall_due.push_back(wall_clock_of(in_word));
      if (out_valid && !out_stall) begin
        if (wall_due.size() == 0) begin
          $error("out word %h with no word expected", out_word);
          mismatches++;
        end else begin
          want = wall_due.pop_front();
          check_field("main_hour", want.main_hour, out_word.main_hour);
          check_field("main_minute", want.main_minute, out_word.main_minute);
          check_field("main_pm", want.main_pm, out_word.main_pm);
          check_field("main_dst", want.main_dst, out_word.main_dst);
          check_field("home_valid", want.home_valid, out_word.home_valid);
          check_field("home_hr", want.home_hr, out_word.home_hr);
          check_field("home_minute", want.home_minute, out_word.home_minute);
          check_field("home_pm", want.home_pm, out_word.home_pm);
        end
      end
    end
    waiting <= wall_due.size();
  end

endmodule

// ===== test/tb.sv =====
// testbench top for the zone clock: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb;
  import dazc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;    // pipe is four stages deep
  localparam int unsigned HOLD_CYCLES   = 120;  // long receiver hold-off
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_WORDS   = 153;
  localparam logic [2:0]  SPARE_INDEX   = 3'd7; // decodes to no register

  typedef struct packed {
    logic signed [10:0] main_off;
    logic [2:0]         main_rule;
    logic signed [10:0] home_off;
    logic [2:0]         home_rule;
    logic               home_on;
    logic               twelve_on;
  } zone_setup_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [10:0] cfg_data;
  int unsigned mismatches;
  int unsigned waiting;
  int unsigned cycles = 0;

  // quiet: no idling on either side; hold_req: ask the receiver for a long hold-off
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  dst_adjusted_zone_clock u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dazc_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver side: random stall bursts, plus the long hold-off on request
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        n = gap_len();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic in_word_t make_word(int unsigned h, int unsigned mi, int unsigned mo,
                                         int unsigned d, int unsigned wd);
    in_word_t w;
    w.utc_hour   = 5'(h);
    w.utc_minute = 6'(mi);
    w.month      = 4'(mo);
    w.day        = 5'(d);
    w.weekday    = 3'(wd);
    return w;
  endfunction

  // mostly legal times with dates piled on the switch-over months, some raw bits
  function automatic in_word_t random_word();
    bit [31:0]   raw;
    int unsigned k;
    int unsigned mo;
    k = $urandom_range(0, 99);
    raw = $urandom;
    if (k < 12) return raw[$bits(in_word_t)-1:0];
    if (k < 70) begin
      case ($urandom_range(0, 4))
        0: mo = 3;
        1: mo = 4;
        2: mo = 9;
        3: mo = 10;
        default: mo = 11;
      endcase
    end else begin
      mo = $urandom_range(1, 12);
    end
    return make_word($urandom_range(0, 23), $urandom_range(0, 59), mo,
                     $urandom_range(1, 31), $urandom_range(0, 6));
  endfunction

  // offsets favor the legal and the 11-bit extremes
  function automatic logic signed [10:0] random_offset();
    case ($urandom_range(0, 9))
      0: return -11'sd720;
      1: return 11'sd840;
      2: return -11'sd1024;
      3: return 11'sd1023;
      default: return 11'($urandom_range(0, 1560) - 720);
    endcase
  endfunction

  function automatic zone_setup_t random_setup();
    zone_setup_t s;
    s.main_off  = random_offset();
    s.main_rule = 3'($urandom_range(0, 7));
    s.home_off  = random_offset();
    s.home_rule = 3'($urandom_range(0, 7));
    s.home_on   = $urandom_range(0, 3) != 0;
    s.twelve_on = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // offer one word and hold it until taken; returns on the next falling edge
  task automatic send_word(input in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int unsigned n;
    n = gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // stop sending and wait for every predicted word to come out
  task automatic drain();
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // leaves cfg_we high so back-to-back writes need no toggle
  task automatic cfg_write(input logic [2:0] idx, input logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic apply_setup(input zone_setup_t s);
    logic [10:0] fill;
    drain();
    fill = 11'($urandom);
    // unused upper data bits carry noise
    cfg_write(REG_MAIN_OFFSET, s.main_off);
    cfg_write(REG_MAIN_RULE, {fill[10:3], s.main_rule});
    cfg_write(REG_HOME_OFFSET, s.home_off);
    cfg_write(REG_HOME_RULE, {fill[7:0], s.home_rule});
    cfg_write(REG_HOME_SHOWN, {fill[10:1], s.home_on});
    cfg_write(REG_TWELVE_HOUR, {fill[9:0], s.twelve_on});
    cfg_write(SPARE_INDEX, 11'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_word_t    corner_words[8];
    zone_setup_t corner_setups[3];
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst       = 1'b1;

    // all-zero word: month 0, day 0; all-ones word: month 15, day 31, weekday seven
    corner_words[0] = make_word(0, 0, 0, 0, 0);
    corner_words[1] = make_word(31, 63, 15, 31, 7);
    corner_words[2] = make_word(23, 59, 12, 31, 6);
    // second sunday of march, last sunday of march
    corner_words[3] = make_word(12, 30, 3, 8, 0);
    corner_words[4] = make_word(1, 0, 3, 31, 0);
    // first sunday of april, last sunday of a 30-day september
    corner_words[5] = make_word(13, 15, 4, 1, 0);
    corner_words[6] = make_word(10, 45, 9, 30, 0);
    // first sunday of november
    corner_words[7] = make_word(0, 5, 11, 1, 0);

    // every rule code except RULE_NONE, offset extremes, both hour modes, home shown and not
    corner_setups[0] = '{-11'sd720, RULE_US, 11'sd840, RULE_EU, 1'b1, 1'b1};
    corner_setups[1] = '{11'sd1023, RULE_AU, -11'sd1024, RULE_NZ, 1'b1, 1'b0};
    corner_setups[2] = '{11'sd330, RULE_CL, 11'sd0, RULE_NF, 1'b0, 1'b1};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part
    for (int s = 0; s < 3; s++) begin
      apply_setup(corner_setups[s]);
      foreach (corner_words[i]) begin
        send_word(corner_words[i]);
        idle_gap();
      end
    end

    // random part, a fresh register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      apply_setup(random_setup());
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // a run with no idling in every phase; in phase 2 the receiver holds off
        // while words keep coming, so the pipe fills and in_stall rises
        quiet = (i >= 100 && i < 130) || (p == 2 && i >= 10 && i < 60);
        if (p == 2 && i == 10) hold_req = 1'b1;
        // sender pause until the pipe has emptied
        if (p == 4 && i == 80) drain();
        send_word(random_word());
        idle_gap();
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
